// ===== rtl/point_cloud_to_disparity_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for point_cloud_to_disparity_map_unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POINT_CLOUD_TO_DISPARITY_MAP_UNIT_MACROS_SVH
`define POINT_CLOUD_TO_DISPARITY_MAP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcd assertion failed");
`define PCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcd assertion failed");
`else
`define PCD_ASSERT_IMP(label, ante, cons)
`define PCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

  localparam int unsigned MAX_WIDTH  = 1280;
  localparam int unsigned MAX_HEIGHT = 720;
  localparam int unsigned STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W     = $clog2(STORE_SIZE);

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CIDX_W    = 4;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MAP_W     = 16;
  localparam int unsigned DEPTH_W   = 32;
  localparam int unsigned SCALE_W   = 40;
  localparam int unsigned WREG_W    = 11;
  localparam int unsigned HREG_W    = 10;
  localparam int unsigned DIM_W     = 13;  // compare width for pixel bounds
  localparam int unsigned XY_W      = 11;  // pixel coordinate, up to 2047
  localparam int unsigned ACC_W     = 52;
  localparam int unsigned NUM_W     = 52;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned DISP_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TDATA_IN_W = 168;

  localparam logic [WREG_W-1:0]  WIDTH_RESET  = 11'd1280;
  localparam logic [HREG_W-1:0]  HEIGHT_RESET = 10'd720;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST  = EPOCH_W'(1);

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POINT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] DSRC_U   = 2'd0;
  localparam logic [1:0] DSRC_V   = 2'd1;
  localparam logic [1:0] DSRC_MAP = 2'd2;

  localparam logic [1:0] OSEL_ZERO = 2'd0;
  localparam logic [1:0] OSEL_SAT  = 2'd1;
  localparam logic [1:0] OSEL_QUO  = 2'd2;

  typedef struct packed {
    logic       coef_wr;
    logic       capture;
    logic       acc_init;
    logic       new_frame;
    logic       clr_wr;
    logic       mul_en;
    logic [1:0] mul_row;
    logic [1:0] mul_col;
    logic       div_start;
    logic [1:0] div_src;
    logic       x_load;
    logic       y_load;
    logic       pt_rd;
    logic       pt_wr;
    logic       map_rd;
    logic       out_load;
    logic [1:0] out_sel;
  } pcd_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic epoch_wrap;
    logic pt_reject;
    logic pt_outside;
    logic map_hit;
    logic map_sat;
    logic div_busy;
    logic div_done;
    logic out_free;
  } pcd_status_t;

endpackage

`default_nettype wire

// ===== rtl/point_cloud_to_disparity_map_unit.sv =====
// ----------------------------------------------------------------------------
// point_cloud_to_disparity_map_unit
// Lidar point projection into a nearest-depth store, with disparity readout.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; tuser is the item kind (load coefficient,
// new frame, point, map entry). Only map entries produce a word on m_axis:
// tdata is the disparity, tuser the has_depth flag. Registers (scale, width,
// height) are to be written over the cfg channel only while the block is
// idle; the block itself does not enforce this. One item is in work at a
// time. A point runs 12 multiplies through one 32x32 multiplier, a drain and
// a check state, then two quotients on the shared divider and then one
// read-modify-write of the depth store. A map entry reads the store, and
// divides scale by depth only for a stored depth that does not saturate.
// After reset, and on every 255th new frame when the frame epoch wraps, a
// clearing pass writes all MAX_WIDTH*MAX_HEIGHT entries, one per cycle;
// no input word is taken during it.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and only a map entry waits if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module point_cloud_to_disparity_map_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // coef_index, coef_value, point_x, point_y, point_z, map_x, map_y, zero pad
  input  wire logic [pcd_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
  // kind
  input  wire logic [pcd_pkg::KIND_W-1:0]          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // disparity
  output logic [pcd_pkg::DISP_W-1:0]               m_axis_tdata,
  // has_depth
  output logic                                     m_axis_tuser,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pcd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [pcd_pkg::SCALE_W-1:0]         cfg_data_i
);

  pcd_pkg::pcd_cmd_t    cmd;
  pcd_pkg::pcd_status_t status;

  assign cfg_ready_o = 1'b1;

  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcd_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .coef_index_i (s_axis_tdata[3:0]),
    .coef_value_i (s_axis_tdata[35:4]),
    .point_x_i    (s_axis_tdata[67:36]),
    .point_y_i    (s_axis_tdata[99:68]),
    .point_z_i    (s_axis_tdata[131:100]),
    .map_x_i      (s_axis_tdata[147:132]),
    .map_y_i      (s_axis_tdata[163:148]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .disparity_o  (m_axis_tdata),
    .has_depth_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/pcd_div.sv =====
// ----------------------------------------------------------------------------
// pcd_div
// Restoring divider, one quotient bit per cycle, 16 quotient bits.
// The caller guarantees num < den * 2^16.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pcd_pkg::NUM_W-1:0]    num_i,
  input  wire logic [pcd_pkg::NUM_W-1:0]    den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [pcd_pkg::QUO_W-1:0]         quo_o
);

  localparam int unsigned DS_W  = pcd_pkg::NUM_W + pcd_pkg::QUO_W - 1;
  localparam int unsigned CNT_W = $clog2(pcd_pkg::QUO_W);

  logic                       busy_q, done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [pcd_pkg::NUM_W-1:0]  rem_q;
  logic [DS_W-1:0]            dsh_q;
  logic [pcd_pkg::QUO_W-1:0]  quo_q;
  logic                       ge;

  assign ge = {{(DS_W-pcd_pkg::NUM_W){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(pcd_pkg::QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(pcd_pkg::QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[pcd_pkg::NUM_W-1:0];
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[pcd_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/pcd_dpath.sv =====
// ----------------------------------------------------------------------------
// pcd_dpath
// Coefficients, projection multiply-accumulate, divider, depth store with
// frame epochs, configuration registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_dpath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pcd_pkg::pcd_cmd_t                  cmd_i,
  output pcd_pkg::pcd_status_t                    status_o,
  input  wire logic                               cfg_valid_i,
  input  wire logic [pcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [pcd_pkg::SCALE_W-1:0]        cfg_data_i,
  input  wire logic [pcd_pkg::CIDX_W-1:0]         coef_index_i,
  input  wire logic signed [pcd_pkg::COEF_W-1:0]  coef_value_i,
  input  wire logic signed [pcd_pkg::COORD_W-1:0] point_x_i,
  input  wire logic signed [pcd_pkg::COORD_W-1:0] point_y_i,
  input  wire logic signed [pcd_pkg::COORD_W-1:0] point_z_i,
  input  wire logic signed [pcd_pkg::MAP_W-1:0]   map_x_i,
  input  wire logic signed [pcd_pkg::MAP_W-1:0]   map_y_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic [pcd_pkg::DISP_W-1:0]              disparity_o,
  output logic                                    has_depth_o
);

  localparam int unsigned ACC_W  = pcd_pkg::ACC_W;
  localparam int unsigned PROD_W = 2 * pcd_pkg::COEF_W;
  localparam int unsigned MEM_W  = pcd_pkg::EPOCH_W + pcd_pkg::DEPTH_W;
  localparam int unsigned ADDR_W = pcd_pkg::ADDR_W;
  localparam int unsigned DIM_W  = pcd_pkg::DIM_W;
  localparam int unsigned XY_W   = pcd_pkg::XY_W;
  localparam logic [DIM_W-1:0] MAXW = DIM_W'(pcd_pkg::MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH = DIM_W'(pcd_pkg::MAX_HEIGHT);

  // configuration
  logic [pcd_pkg::SCALE_W-1:0] scale_q;
  logic [pcd_pkg::WREG_W-1:0]  width_q;
  logic [pcd_pkg::HREG_W-1:0]  height_q;
  logic [DIM_W-1:0]            eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= '0;
      width_q  <= pcd_pkg::WIDTH_RESET;
      height_q <= pcd_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcd_pkg::CFG_SCALE:  scale_q  <= cfg_data_i;
        pcd_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[pcd_pkg::WREG_W-1:0];
        pcd_pkg::CFG_HEIGHT: height_q <= cfg_data_i[pcd_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = (DIM_W'(width_q) > MAXW) ? MAXW : DIM_W'(width_q);
  assign eff_h = (DIM_W'(height_q) > MAXH) ? MAXH : DIM_W'(height_q);

  // coefficients and captured item
  logic signed [pcd_pkg::COEF_W-1:0]  coef_q [16];
  logic signed [pcd_pkg::COORD_W-1:0] px_q, py_q, pz_q;
  logic signed [pcd_pkg::MAP_W-1:0]   mx_q, my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) coef_q[i] <= '0;
    end else if (cmd_i.coef_wr) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      pz_q <= point_z_i;
      mx_q <= map_x_i;
      my_q <= map_y_i;
    end
  end

  // multiply, then accumulate the floored Q16.16 product into its row
  logic signed [pcd_pkg::COORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0]           prod_q;
  logic [1:0]                         prow_q;
  logic                               pv_q;
  logic signed [ACC_W-1:0]            acc_q [4];
  logic signed [PROD_W-17:0]          prod_sh;

  always_comb begin
    case (cmd_i.mul_col)
      2'd0:    mul_b = px_q;
      2'd1:    mul_b = py_q;
      default: mul_b = pz_q;
    endcase
  end

  assign prod_sh = prod_q[PROD_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= coef_q[{cmd_i.mul_row, cmd_i.mul_col}] * mul_b;
      prow_q <= cmd_i.mul_row;
    end
    if (cmd_i.acc_init) begin
      for (int r = 0; r < 4; r++) acc_q[r] <= ACC_W'(coef_q[r*4+3]);
    end else if (pv_q) begin
      acc_q[prow_q] <= acc_q[prow_q] + ACC_W'(prod_sh);
    end
  end

  // projection checks: u, v, w, d in rows 0..3
  logic signed [ACC_W-1:0] u, v, w, d;
  logic                    w_pos, d_pos, u_rej, v_rej;
  logic [ACC_W-1:0]        u_mag, v_mag;
  logic [pcd_pkg::DEPTH_W-1:0] dd;

  assign u = acc_q[0];
  assign v = acc_q[1];
  assign w = acc_q[2];
  assign d = acc_q[3];
  assign w_pos = !w[ACC_W-1] && (w != '0);
  assign d_pos = !d[ACC_W-1] && (d != '0);
  assign u_mag = -u;
  assign v_mag = -v;
  // negative quotient, or one of 2048 and above: off the image either way
  assign u_rej = u[ACC_W-1] ? (u_mag >= w)
               : ({{XY_W{1'b0}}, u} >= {w, {XY_W{1'b0}}});
  assign v_rej = v[ACC_W-1] ? (v_mag >= w)
               : ({{XY_W{1'b0}}, v} >= {w, {XY_W{1'b0}}});
  assign dd = (d[ACC_W-1:pcd_pkg::DEPTH_W] != '0) ? '1 : d[pcd_pkg::DEPTH_W-1:0];

  // divider
  logic [pcd_pkg::NUM_W-1:0] div_num, div_den;
  logic                      div_busy, div_done;
  logic [pcd_pkg::QUO_W-1:0] quo;
  logic [pcd_pkg::DEPTH_W-1:0] rd_depth;
  logic [pcd_pkg::EPOCH_W-1:0] rd_epoch;

  always_comb begin
    case (cmd_i.div_src)
      pcd_pkg::DSRC_U: begin
        div_num = u[ACC_W-1] ? '0 : u;
        div_den = w;
      end
      pcd_pkg::DSRC_V: begin
        div_num = v[ACC_W-1] ? '0 : v;
        div_den = w;
      end
      default: begin
        div_num = pcd_pkg::NUM_W'(scale_q);
        div_den = pcd_pkg::NUM_W'(rd_depth);
      end
    endcase
  end

  pcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  logic [XY_W-1:0] x_q, y_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.x_load) x_q <= quo[XY_W-1:0];
    if (cmd_i.y_load) y_q <= quo[XY_W-1:0];
  end

  // map coordinates: round half away from zero
  localparam int unsigned MAP_W_P = pcd_pkg::MAP_W + 1;
  logic [MAP_W_P-1:0] mx_mag, my_mag;
  logic [DIM_W-1:0] rx, ry;
  logic             map_ok, map_ok_q;

  assign mx_mag = mx_q[pcd_pkg::MAP_W-1] ? -MAP_W_P'(mx_q) : MAP_W_P'(mx_q);
  assign my_mag = my_q[pcd_pkg::MAP_W-1] ? -MAP_W_P'(my_q) : MAP_W_P'(my_q);
  assign rx = DIM_W'((mx_mag + MAP_W_P'(8)) >> 4);
  assign ry = DIM_W'((my_mag + MAP_W_P'(8)) >> 4);
  assign map_ok = (!mx_q[pcd_pkg::MAP_W-1] || rx == '0) && (rx < eff_w)
               && (!my_q[pcd_pkg::MAP_W-1] || ry == '0) && (ry < eff_h);

  // depth store
  localparam logic [pcd_pkg::EPOCH_W-1:0] EPOCH_W_ONE = pcd_pkg::EPOCH_W'(1);
  logic [ADDR_W-1:0]  pt_idx, map_idx, clr_q, waddr, raddr;
  logic [MEM_W-1:0]   mem [pcd_pkg::STORE_SIZE];
  logic [MEM_W-1:0]   rdata_q, wdata;
  logic               we, re;
  logic [pcd_pkg::EPOCH_W-1:0] epoch_q;

  assign pt_idx  = ADDR_W'(y_q) * ADDR_W'(pcd_pkg::MAX_WIDTH) + ADDR_W'(x_q);
  assign map_idx = ADDR_W'(ry[XY_W-1:0]) * ADDR_W'(pcd_pkg::MAX_WIDTH)
                 + ADDR_W'(rx[XY_W-1:0]);
  assign rd_epoch = rdata_q[MEM_W-1:pcd_pkg::DEPTH_W];
  assign rd_depth = rdata_q[pcd_pkg::DEPTH_W-1:0];

  assign re    = cmd_i.pt_rd || cmd_i.map_rd;
  assign raddr = cmd_i.pt_rd ? pt_idx : map_idx;
  assign we    = cmd_i.clr_wr
              || (cmd_i.pt_wr && (rd_epoch != epoch_q || rd_depth > dd));
  assign waddr = cmd_i.clr_wr ? clr_q : pt_idx;
  assign wdata = cmd_i.clr_wr ? '0 : {epoch_q, dd};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      epoch_q  <= pcd_pkg::EPOCH_FIRST;
      map_ok_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= (clr_q == ADDR_W'(pcd_pkg::STORE_SIZE - 1)) ? '0 : clr_q + ADDR_W'(1);
      end
      // epoch zero marks a cleared entry; wrap restarts at the first epoch
      if (cmd_i.new_frame) begin
        epoch_q <= (epoch_q == '1) ? pcd_pkg::EPOCH_FIRST : epoch_q + EPOCH_W_ONE;
      end
      if (cmd_i.map_rd) map_ok_q <= map_ok;
    end
  end

  // output register
  logic                       out_v_q, has_q;
  logic [pcd_pkg::DISP_W-1:0] disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        pcd_pkg::OSEL_SAT: begin
          disp_q <= '1;
          has_q  <= 1'b1;
        end
        pcd_pkg::OSEL_QUO: begin
          disp_q <= quo;
          has_q  <= 1'b1;
        end
        default: begin
          disp_q <= '0;
          has_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign disparity_o = disp_q;
  assign has_depth_o = has_q;

  always_comb begin
    status_o.clr_last   = (clr_q == ADDR_W'(pcd_pkg::STORE_SIZE - 1));
    status_o.epoch_wrap = (epoch_q == '1);
    status_o.pt_reject  = !w_pos || !d_pos || u_rej || v_rej;
    status_o.pt_outside = (DIM_W'(x_q) >= eff_w) || (DIM_W'(y_q) >= eff_h);
    status_o.map_hit    = map_ok_q && (rd_epoch == epoch_q) && (rd_depth != '0);
    status_o.map_sat    = {8'b0, scale_q} >= {rd_depth, 16'b0};
    status_o.div_busy   = div_busy;
    status_o.div_done   = div_done;
    status_o.out_free   = !out_v_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ===== rtl/pcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcd_ctrl
// Sequencer: clearing pass, item dispatch, projection, division and
// depth store update or readout.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_cloud_to_disparity_map_unit_macros.svh"

module pcd_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic [pcd_pkg::KIND_W-1:0]     in_kind_i,
  output logic                                in_ready_o,
  input  wire pcd_pkg::pcd_status_t           status_i,
  output pcd_pkg::pcd_cmd_t                   cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_DIVX  = 4'd5;
  localparam logic [3:0] S_DIVY  = 4'd6;
  localparam logic [3:0] S_PIDX  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_MRD   = 4'd9;
  localparam logic [3:0] S_MCHK  = 4'd10;
  localparam logic [3:0] S_MDIV  = 4'd11;
  localparam logic [3:0] S_MOUT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [1:0] row_q, row_d, col_q, col_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.mul_row = row_q;
    cmd_o.mul_col = col_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          case (in_kind_i)
            pcd_pkg::KIND_LOAD: cmd_o.coef_wr = 1'b1;
            pcd_pkg::KIND_FRAME: begin
              cmd_o.new_frame = 1'b1;
              if (status_i.epoch_wrap) state_d = S_CLEAR;
            end
            pcd_pkg::KIND_POINT: begin
              cmd_o.acc_init = 1'b1;
              row_d   = 2'd0;
              col_d   = 2'd0;
              state_d = S_MUL;
            end
            default: state_d = S_MRD;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (col_q == 2'd2) begin
          col_d = 2'd0;
          row_d = row_q + 2'd1;
          if (row_q == 2'd3) state_d = S_DRAIN;
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      S_DRAIN: state_d = S_CHK;
      S_CHK: begin
        if (status_i.pt_reject) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = pcd_pkg::DSRC_U;
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd_o.div_src = pcd_pkg::DSRC_V;
        if (status_i.div_done) begin
          cmd_o.x_load    = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (status_i.div_done) begin
          cmd_o.y_load = 1'b1;
          state_d = S_PIDX;
        end
      end
      S_PIDX: begin
        if (status_i.pt_outside) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.pt_rd = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        cmd_o.pt_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_MRD: begin
        cmd_o.map_rd = 1'b1;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        cmd_o.div_src = pcd_pkg::DSRC_MAP;
        if (!status_i.map_hit) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = pcd_pkg::OSEL_ZERO;
            state_d = S_IDLE;
          end
        end else if (status_i.map_sat) begin
          if (status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = pcd_pkg::OSEL_SAT;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        if (status_i.div_done) state_d = S_MOUT;
      end
      S_MOUT: begin
        // hold the quotient until the output register frees up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = pcd_pkg::OSEL_QUO;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      row_q   <= 2'd0;
      col_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  `PCD_ASSERT_IMP(a_out_free, cmd_o.out_load, status_i.out_free)
  `PCD_ASSERT_IMP(a_div_idle, cmd_o.div_start, !status_i.div_busy)
  `PCD_ASSERT_IMP(a_wr_after_rd, cmd_o.pt_wr, $past(cmd_o.pt_rd))
  `PCD_ASSERT_NEXT(a_clr_end, state_q == S_CLEAR && status_i.clr_last, state_q == S_IDLE)

endmodule

`default_nettype wire

// ===== tb/sv/tb_point_cloud_to_disparity_map_unit.sv =====
// ----------------------------------------------------------------------------
// tb_point_cloud_to_disparity_map_unit
// Self-checking bench: point projection, nearest-depth store and disparity
// readout are predicted in the bench and compared word by word on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_cloud_to_disparity_map_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 4_000_000;  // covers the clearing pass
  localparam int unsigned SETTLE_CYC  = 80;         // longer than a point item
  localparam int unsigned RAND_PER_PH = 300;
  localparam int          ONE_Q16     = 32'h0001_0000;

  typedef struct {
    logic [pcd_pkg::KIND_W-1:0] kind;
    logic [3:0]        coef_index;
    int                coef_value;
    int                point_x;
    int                point_y;
    int                point_z;
    shortint           map_x;
    shortint           map_y;
  } lidar_word_t;

  typedef struct {
    logic [pcd_pkg::DISP_W-1:0] disparity;
    logic              has_depth;
  } disp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [pcd_pkg::TDATA_IN_W-1:0] s_axis_tdata = '0;
  logic [pcd_pkg::KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [pcd_pkg::DISP_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pcd_pkg::SCALE_W-1:0] cfg_data_i = '0;

  point_cloud_to_disparity_map_unit u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Bench copy of the block state
  int                 coef_mem [16];
  bit [31:0]          nearest_depth [int];
  longint unsigned    scale_reg = 0;
  bit [pcd_pkg::WREG_W-1:0] width_reg = pcd_pkg::WIDTH_RESET;
  bit [pcd_pkg::HREG_W-1:0] height_reg = pcd_pkg::HEIGHT_RESET;

  lidar_word_t  word_q [$];
  disp_result_t disp_expect_q [$];
  int unsigned  err_cnt = 0;
  int unsigned  out_cnt = 0;

  function automatic longint row_sum(int r, longint px, longint py, longint pz);
    longint acc;
    acc = longint'(coef_mem[r*4+3]);
    acc += (longint'(coef_mem[r*4+0]) * px) >>> 16;
    acc += (longint'(coef_mem[r*4+1]) * py) >>> 16;
    acc += (longint'(coef_mem[r*4+2]) * pz) >>> 16;
    return acc;
  endfunction

  function automatic longint round_pixel(longint v);
    if (v >= 0) return (v + 8) >>> 4;
    return -(((-v) + 8) >>> 4);
  endfunction

  function automatic longint eff_width();
    return (width_reg > pcd_pkg::MAX_WIDTH) ? pcd_pkg::MAX_WIDTH : width_reg;
  endfunction

  function automatic longint eff_height();
    return (height_reg > pcd_pkg::MAX_HEIGHT) ? pcd_pkg::MAX_HEIGHT : height_reg;
  endfunction

  function automatic void predict_word(lidar_word_t w);
    longint u, v, hw, d, x, y;
    longint unsigned q;
    bit [31:0] dd;
    int idx;
    disp_result_t r;
    case (w.kind)
      pcd_pkg::KIND_LOAD: coef_mem[w.coef_index] = w.coef_value;
      pcd_pkg::KIND_FRAME: nearest_depth.delete();
      pcd_pkg::KIND_POINT: begin
        u  = row_sum(0, w.point_x, w.point_y, w.point_z);
        v  = row_sum(1, w.point_x, w.point_y, w.point_z);
        hw = row_sum(2, w.point_x, w.point_y, w.point_z);
        d  = row_sum(3, w.point_x, w.point_y, w.point_z);
        if (hw > 0 && d > 0) begin
          x = u / hw;
          y = v / hw;
          if (x >= 0 && y >= 0 && x < eff_width() && y < eff_height()) begin
            dd = (d > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
            idx = int'(y) * pcd_pkg::MAX_WIDTH + int'(x);
            if (!nearest_depth.exists(idx) || nearest_depth[idx] > dd)
              nearest_depth[idx] = dd;
          end
        end
      end
      default: begin
        x = round_pixel(w.map_x);
        y = round_pixel(w.map_y);
        r.disparity = '0;
        r.has_depth = 1'b0;
        if (x >= 0 && y >= 0 && x < eff_width() && y < eff_height()) begin
          idx = int'(y) * pcd_pkg::MAX_WIDTH + int'(x);
          if (nearest_depth.exists(idx) && nearest_depth[idx] != 0) begin
            q = scale_reg / longint'(nearest_depth[idx]);
            r.disparity = (q > 65535) ? 16'hFFFF : q[15:0];
            r.has_depth = 1'b1;
          end
        end
        disp_expect_q.push_back(r);
      end
    endcase
  endfunction

  // Every field gets random bits and only the kind is set; callers set the kind's own fields
  function automatic lidar_word_t noise_word(logic [pcd_pkg::KIND_W-1:0] k);
    lidar_word_t w;
    w.kind = k;
    w.coef_index = 4'($urandom_range(0, 15));
    w.coef_value = $urandom;
    w.point_x = $urandom;
    w.point_y = $urandom;
    w.point_z = $urandom;
    w.map_x = shortint'($urandom);
    w.map_y = shortint'($urandom);
    return w;
  endfunction

  function automatic void push_coef(int slot, int value);
    lidar_word_t w;
    w = noise_word(pcd_pkg::KIND_LOAD);
    w.coef_index = 4'(slot);
    w.coef_value = value;
    word_q.push_back(w);
  endfunction

  function automatic int nominal_coef(int slot);
    return (slot == 0 || slot == 5 || slot == 10 || slot == 14) ? ONE_Q16 : 0;
  endfunction

  // Pixel (tx,ty) under the nominal projection u=x, v=y, w=z, d=z
  function automatic void push_point(int tx, int ty, int z);
    lidar_word_t w;
    w = noise_word(pcd_pkg::KIND_POINT);
    w.point_z = z;
    w.point_x = tx * z + $urandom_range(0, z - 1);
    w.point_y = ty * z + $urandom_range(0, z - 1);
    word_q.push_back(w);
  endfunction

  function automatic void push_map(int mx, int my);
    lidar_word_t w;
    w = noise_word(pcd_pkg::KIND_MAP);
    w.map_x = shortint'(mx);
    w.map_y = shortint'(my);
    word_q.push_back(w);
  endfunction

  function automatic int pick_coord(int lim);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return (lim > 1) ? $urandom_range(0, (lim < 16 ? lim : 16) - 1) : 0;
    if (sel == 7) return (lim > 0) ? lim - 1 : 0;
    if (sel == 8) return lim;
    return $urandom_range(0, 1400);
  endfunction

  function automatic void push_random_part(int n);
    int sel, wl, hl;
    wl = int'(eff_width());
    hl = int'(eff_height());
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2)
        word_q.push_back(noise_word(pcd_pkg::KIND_FRAME));
      else if (sel < 4)
        push_coef($urandom_range(0, 15), $urandom);
      else if (sel < 6) begin
        sel = $urandom_range(0, 15);
        push_coef(sel, nominal_coef(sel));
      end else if (sel < 10)
        word_q.push_back(noise_word(pcd_pkg::KIND_POINT));
      else if (sel < 14)
        word_q.push_back(noise_word(pcd_pkg::KIND_MAP));
      else if (sel < 55)
        push_point(pick_coord(wl), pick_coord(hl), $urandom_range(32'h8000, 32'hF_FFFF));
      else
        push_map(pick_coord(wl) * 16 + $urandom_range(0, 15) - 8,
                 pick_coord(hl) * 16 + $urandom_range(0, 15) - 8);
    end
  endfunction

  task automatic write_reg(logic [pcd_pkg::CFG_IDX_W-1:0] idx, longint unsigned value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[pcd_pkg::SCALE_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pcd_pkg::CFG_SCALE:  scale_reg = value & 64'hFF_FFFF_FFFF;
      pcd_pkg::CFG_WIDTH:  width_reg = value[pcd_pkg::WREG_W-1:0];
      default:             height_reg = value[pcd_pkg::HREG_W-1:0];
    endcase
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || s_axis_tvalid || disp_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_phase(longint unsigned scale, int w, int h);
    wait_drained();
    write_reg(pcd_pkg::CFG_SCALE, scale);
    write_reg(pcd_pkg::CFG_WIDTH, w);
    write_reg(pcd_pkg::CFG_HEIGHT, h);
  endtask

  // Stimulus sequencing
  initial begin
    for (int i = 0; i < 16; i++) coef_mem[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_phase(64'h3_0000_0000, 1280, 720);
    for (int i = 0; i < 16; i++) push_coef(i, nominal_coef(i));
    push_point(0, 0, 32'h0000_8000);
    push_point(1279, 719, 32'h0001_0000);
    push_point(5, 5, 32'hFFFF_0000);            // behind the camera
    push_point(1280, 2, 32'h0001_0000);         // x equal to width
    push_map(7, 0);
    push_map(1279 * 16, 719 * 16 + 7);
    push_map(-8, 0);
    push_map(32767, -32768);
    push_coef(15, 32'h8000_0000);               // depth goes negative
    push_point(2, 2, 32'h0002_0000);
    push_coef(14, 32'h7FFF_FFFF);               // depth above 32 bits
    push_coef(15, 0);
    push_point(3, 3, 32'h0004_0000);
    push_map(3 * 16, 3 * 16);
    push_map(2 * 16, 2 * 16);
    push_coef(14, ONE_Q16);
    word_q.push_back(noise_word(pcd_pkg::KIND_FRAME));
    push_map(0, 0);
    push_random_part(RAND_PER_PH);

    set_phase(64'hFF_FFFF_FFFF, 16, 16);
    push_random_part(RAND_PER_PH);
    set_phase(0, 1, 1);
    push_random_part(RAND_PER_PH / 2);
    set_phase({$urandom_range(0, 255), $urandom}, 2047, 1023);
    push_random_part(RAND_PER_PH);
    set_phase($urandom, 0, 5);
    push_random_part(RAND_PER_PH / 2);
    set_phase({$urandom_range(0, 15), $urandom}, 20, 12);
    push_random_part(RAND_PER_PH);
    set_phase({$urandom_range(0, 255), $urandom}, 1280, 720);
    push_random_part(RAND_PER_PH);

    wait_drained();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Input driver: bursts of words with random gaps
  lidar_word_t cur;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_word(cur);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() != 0) begin
          cur = word_q.pop_front();
          s_axis_tdata <= {4'b0, cur.map_y, cur.map_x, cur.point_z, cur.point_y,
                           cur.point_x, cur.coef_value, cur.coef_index};
          s_axis_tuser <= cur.kind;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern, with one long hold-off to back up the input
  int unsigned stall_left = 0;
  int unsigned pattern_cnt = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      pattern_cnt++;
      if (!long_hold_done && out_cnt >= 20) begin
        long_hold_done = 1'b1;
        stall_left = 600;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (pattern_cnt[8] && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker
  disp_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_cnt++;
      if (disp_expect_q.size() == 0) begin
        $error("unexpected result word: disparity %0d has_depth %0d",
               m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        want = disp_expect_q.pop_front();
        if (m_axis_tdata !== want.disparity) begin
          $error("disparity: expected %0d, got %0d", want.disparity, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== want.has_depth) begin
          $error("has_depth: expected %0d, got %0d", want.has_depth, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  int unsigned idle_cyc = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/pcd_pkg.sv
rtl/pcd_div.sv
rtl/pcd_dpath.sv
rtl/pcd_ctrl.sv
rtl/point_cloud_to_disparity_map_unit.sv
tb/sv/tb_point_cloud_to_disparity_map_unit.sv
